[rtl/bfa_pkg.sv]
package bfa_pkg;

    localparam int MAX_FRAMES_DEF = 4096;
    localparam int FRAME_W        = 12;
    localparam int CNT_W          = 13;
    localparam int WORD_W         = 32;
    localparam int BIT_W          = 5;
    localparam int GROUP_SZ       = 8;
    localparam int GROUP_SEL_W    = 3;
    localparam int FRAME_COUNT_RST = 4096;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NOP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [FRAME_W-1:0] frame_index;
        logic               kernel_only;
        logic               want_write;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic               present;
        logic               writeable;
        logic               user_mode;
        logic [1:0]         status;
        logic               bit_used;
    } t_rsp;

    // Update of the per-word summary (word is full of used frames).
    typedef struct packed {
        logic en;
        logic full;
    } t_sum_upd;

endpackage

[rtl/bfa_bitmap_ram.sv]
module bfa_bitmap_ram #(
    parameter int DEPTH = bfa_pkg::MAX_FRAMES_DEF / bfa_pkg::WORD_W,
    parameter int AW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [bfa_pkg::WORD_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [bfa_pkg::WORD_W-1:0]  o_rdata
);

    logic [bfa_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [bfa_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bfa_search.sv]
module bfa_search #(
    parameter int WORD_COUNT = bfa_pkg::MAX_FRAMES_DEF / bfa_pkg::WORD_W,
    parameter int AW         = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bfa_pkg::t_sum_upd          i_upd,
    input  logic [AW-1:0]              i_upd_addr,
    input  logic [bfa_pkg::CNT_W-1:0]  i_frame_count,
    output logic                       o_hit,
    output logic [AW-1:0]              o_word
);

    localparam int GS  = bfa_pkg::GROUP_SZ;
    localparam int GSW = bfa_pkg::GROUP_SEL_W;
    localparam int NG  = (WORD_COUNT + GS - 1) / GS;

    logic [WORD_COUNT-1:0] r_full;
    logic [NG-1:0]         n_grp_any;
    logic [GSW-1:0]        n_grp_sel [NG];
    logic [NG-1:0]         r_grp_any;
    logic [GSW-1:0]        r_grp_sel [NG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
        end else if (i_upd.en) begin
            r_full[i_upd_addr] <= i_upd.full;
        end
    end

    // First stage: lowest searchable non-full word inside each group of eight.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp_any[g] = 1'b0;
            n_grp_sel[g] = '0;
            for (int k = GS - 1; k >= 0; k--) begin
                if (g * GS + k < WORD_COUNT) begin
                    if (!r_full[g * GS + k] &&
                        (32'(g * GS + k) < 32'(i_frame_count[bfa_pkg::CNT_W-1:bfa_pkg::BIT_W]))) begin
                        n_grp_any[g] = 1'b1;
                        n_grp_sel[g] = GSW'(k);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_any <= n_grp_any;
        for (int g = 0; g < NG; g++) begin
            r_grp_sel[g] <= n_grp_sel[g];
        end
    end

    // Second stage: lowest group with a candidate word.
    always_comb begin
        o_hit  = 1'b0;
        o_word = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                o_hit  = 1'b1;
                o_word = AW'(g * GS) | AW'(r_grp_sel[g]);
            end
        end
    end

endmodule

[rtl/bitmap_frame_allocator.sv]
// Allocate for a page holding no frame: summary scan, group pick, bitmap read-modify-write;
// with no free frame in the searched words it ends after the pick. Every other request:
// one bitmap read and write. A new request is taken only once the last one is done.
// Reset (synchronous, active low) sets frame_count to 4096 and clears the bitmap RAM one
// word per cycle; input stall stays high until that pass is done.
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [bfa_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  bfa_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output bfa_pkg::t_rsp o_out_data
);

    localparam int WORD_COUNT   = MAX_FRAMES / bfa_pkg::WORD_W;
    localparam int AW           = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int STORE_FRAMES = WORD_COUNT * bfa_pkg::WORD_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_PICK  = 6'b001000,
        S_RMW   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [bfa_pkg::CNT_W-1:0] r_frame_count;
    logic [AW-1:0]             r_clr_addr;
    bfa_pkg::t_req             r_req;
    logic [AW-1:0]             r_addr;
    bfa_pkg::t_rsp             r_out;
    logic                      r_out_valid;
    bfa_pkg::t_rsp             r_pend;

    logic                      accept;
    logic                      out_free;
    logic                      finish;
    bfa_pkg::t_rsp             n_rsp;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [bfa_pkg::WORD_W-1:0] ram_wdata;
    logic                      ram_re;
    logic [AW-1:0]             ram_raddr;
    logic [bfa_pkg::WORD_W-1:0] ram_rdata;

    bfa_pkg::t_sum_upd         sum_upd;
    logic                      srch_hit;
    logic [AW-1:0]             srch_word;

    logic                      in_store;
    logic [bfa_pkg::BIT_W-1:0] free_bit;
    logic [bfa_pkg::WORD_W-1:0] bit_mask;
    logic [bfa_pkg::WORD_W-1:0] alloc_word;

    bfa_bitmap_ram #(
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bfa_search #(
        .WORD_COUNT (WORD_COUNT),
        .AW         (AW)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_upd         (sum_upd),
        .i_upd_addr    (r_addr),
        .i_frame_count (r_frame_count),
        .o_hit         (srch_hit),
        .o_word        (srch_word)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_store = (32'(r_req.frame_index) < 32'(STORE_FRAMES));

    // Lowest clear bit of the word read back; the summary guarantees one exists.
    always_comb begin
        free_bit = '0;
        for (int b = bfa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!ram_rdata[b]) begin
                free_bit = bfa_pkg::BIT_W'(b);
            end
        end
    end

    assign alloc_word = ram_rdata | (bfa_pkg::WORD_W'(1) << free_bit);
    assign bit_mask   = bfa_pkg::WORD_W'(1) << r_req.frame_index[bfa_pkg::BIT_W-1:0];

    always_comb begin
        n_rsp              = '0;
        n_rsp.result_frame = r_req.frame_index;
        n_rsp.status       = bfa_pkg::ST_NOP;
        ram_we             = 1'b0;
        ram_waddr          = r_addr;
        ram_wdata          = '0;
        sum_upd            = '0;
        finish             = 1'b0;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            S_PICK: begin
                if (!srch_hit) begin
                    finish             = 1'b1;
                    n_rsp.result_frame = '0;
                    n_rsp.status       = bfa_pkg::ST_FULL;
                end
            end
            S_RMW: begin
                finish = 1'b1;
                case (r_req.opcode)
                    bfa_pkg::OP_ALLOC: begin
                        // Only a page with frame zero reaches here through the scan.
                        if (r_req.frame_index == '0) begin
                            ram_we             = 1'b1;
                            ram_wdata          = alloc_word;
                            sum_upd.en         = 1'b1;
                            sum_upd.full       = &alloc_word;
                            n_rsp.result_frame = bfa_pkg::FRAME_W'({r_addr, free_bit});
                            n_rsp.present      = 1'b1;
                            n_rsp.writeable    = r_req.want_write;
                            n_rsp.user_mode    = !r_req.kernel_only;
                            n_rsp.status       = bfa_pkg::ST_DONE;
                        end
                    end
                    bfa_pkg::OP_FREE: begin
                        n_rsp.result_frame = '0;
                        if (r_req.frame_index != '0) begin
                            n_rsp.status = bfa_pkg::ST_DONE;
                            if (in_store) begin
                                ram_we       = 1'b1;
                                ram_wdata    = ram_rdata & ~bit_mask;
                                sum_upd.en   = 1'b1;
                                sum_upd.full = 1'b0;
                            end
                        end
                    end
                    bfa_pkg::OP_TEST: begin
                        n_rsp.status   = bfa_pkg::ST_DONE;
                        n_rsp.bit_used = in_store &&
                            ram_rdata[r_req.frame_index[bfa_pkg::BIT_W-1:0]];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Read port: the request's own word on accept, the chosen word after the pick.
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = AW'(i_in_data.frame_index[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W]);
        if (accept) begin
            ram_re = 1'b1;
        end else if ((r_state == S_PICK) && srch_hit) begin
            ram_re    = 1'b1;
            ram_raddr = srch_word;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(WORD_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if ((i_in_data.opcode == bfa_pkg::OP_ALLOC) &&
                        (i_in_data.frame_index == '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RMW;
                    end
                end
            end
            S_SCAN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                if (srch_hit) begin
                    n_state = S_RMW;
                end else begin
                    n_state = out_free ? S_IDLE : S_DONE;
                end
            end
            S_RMW: begin
                n_state = out_free ? S_IDLE : S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_frame_count <= bfa_pkg::CNT_W'(bfa_pkg::FRAME_COUNT_RST);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (finish && out_free) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_in_data;
            r_addr <= ram_raddr;
        end else if ((r_state == S_PICK) && srch_hit) begin
            r_addr <= srch_word;
        end
        if (finish) begin
            if (out_free) begin
                r_out <= n_rsp;
            end else begin
                r_pend <= n_rsp;
            end
        end else if ((r_state == S_DONE) && out_free) begin
            r_out <= r_pend;
        end
    end

endmodule

[sim/bitmap_frame_allocator_tb.sv]
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;

    // The block ignores opcode 3 and echoes the frame back as a no-op.
    localparam logic [1:0] OP_RSVD = 2'd3;
    localparam int WORD_CNT = bfa_pkg::MAX_FRAMES_DEF / bfa_pkg::WORD_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_CNT = 7;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        bit                        is_cfg;
        logic [bfa_pkg::CNT_W-1:0] cfg_val;
        bfa_pkg::t_req             req;
        bit                        typed;
        bfa_pkg::t_rsp             rsp;
    } t_plan_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [bfa_pkg::CNT_W-1:0] i_cfg_wdata;
    logic                      i_in_valid;
    logic                      o_in_stall;
    bfa_pkg::t_req             i_in_data;
    logic                      o_out_valid;
    logic                      i_out_stall;
    bfa_pkg::t_rsp             o_out_data;

    // Predictor state: one bit per frame and the current frame_count.
    logic [bfa_pkg::WORD_W-1:0]  used_frames [WORD_CNT];
    logic [bfa_pkg::CNT_W-1:0]   frame_limit;
    bfa_pkg::t_rsp               awaited_rsps [$];
    logic [bfa_pkg::FRAME_W-1:0] held_frames [$];
    t_plan_row                   directed_plan [$];

    logic [bfa_pkg::CNT_W-1:0] phase_frames [PHASE_CNT] = '{64, 4096, 96, 31, 8191, 100, 32};

    int in_idle_pct   = 10;
    int out_stall_pct = 65;
    int error_count   = 0;
    int cycle_count   = 0;

    bitmap_frame_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bitmap_frame_allocator_tb: errors");
            $finish;
        end
    end

    // First-fit search over the whole words below frame_count, then bitmap update.
    function automatic bfa_pkg::t_rsp predict_frame_rsp(input bfa_pkg::t_req r);
        bfa_pkg::t_rsp rsp;
        int   words;
        int   found;
        logic [bfa_pkg::FRAME_W-bfa_pkg::BIT_W-1:0] w_sel;
        logic [bfa_pkg::BIT_W-1:0]                  b_sel;
        w_sel = r.frame_index[bfa_pkg::FRAME_W-1:bfa_pkg::BIT_W];
        b_sel = r.frame_index[bfa_pkg::BIT_W-1:0];
        rsp = '0;
        rsp.result_frame = r.frame_index;
        rsp.status = bfa_pkg::ST_NOP;
        case (r.opcode)
            bfa_pkg::OP_ALLOC: begin
                if (r.frame_index == '0) begin
                    words = frame_limit / bfa_pkg::WORD_W;
                    if (words > WORD_CNT)
                        words = WORD_CNT;
                    found = -1;
                    for (int w = 0; w < words && found < 0; w++)
                        for (int b = 0; b < bfa_pkg::WORD_W && found < 0; b++)
                            if (!used_frames[w][b])
                                found = w * bfa_pkg::WORD_W + b;
                    if (found >= 0) begin
                        used_frames[found / bfa_pkg::WORD_W][found % bfa_pkg::WORD_W] = 1'b1;
                        rsp.result_frame = found[bfa_pkg::FRAME_W-1:0];
                        rsp.present = 1'b1;
                        rsp.writeable = r.want_write;
                        rsp.user_mode = !r.kernel_only;
                        rsp.status = bfa_pkg::ST_DONE;
                    end else begin
                        rsp.result_frame = '0;
                        rsp.status = bfa_pkg::ST_FULL;
                    end
                end
            end
            bfa_pkg::OP_FREE: begin
                if (r.frame_index != '0) begin
                    used_frames[w_sel][b_sel] = 1'b0;
                    rsp.status = bfa_pkg::ST_DONE;
                end
                rsp.result_frame = '0;
            end
            bfa_pkg::OP_TEST: begin
                rsp.bit_used = used_frames[w_sel][b_sel];
                rsp.status = bfa_pkg::ST_DONE;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void row_req(input logic [1:0] op,
                                    input logic [bfa_pkg::FRAME_W-1:0] fi,
                                    input logic kern, input logic wr);
        t_plan_row row;
        row = '{default: '0};
        row.req.opcode = op;
        row.req.frame_index = fi;
        row.req.kernel_only = kern;
        row.req.want_write = wr;
        directed_plan.push_back(row);
    endfunction

    function automatic void row_chk(input logic [1:0] op,
                                    input logic [bfa_pkg::FRAME_W-1:0] fi,
                                    input logic kern, input logic wr,
                                    input logic [bfa_pkg::FRAME_W-1:0] frame,
                                    input logic pres, input logic wflag, input logic user,
                                    input logic [1:0] st, input logic used);
        row_req(op, fi, kern, wr);
        directed_plan[$].typed = 1'b1;
        directed_plan[$].rsp.result_frame = frame;
        directed_plan[$].rsp.present = pres;
        directed_plan[$].rsp.writeable = wflag;
        directed_plan[$].rsp.user_mode = user;
        directed_plan[$].rsp.status = st;
        directed_plan[$].rsp.bit_used = used;
    endfunction

    function automatic void row_cfg(input logic [bfa_pkg::CNT_W-1:0] v);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_val = v;
        directed_plan.push_back(row);
    endfunction

    // Mostly allocate/free/test traffic on frames that pages really hold,
    // with stray frees, stale allocations and ignored opcodes mixed in.
    function automatic bfa_pkg::t_req random_req();
        bfa_pkg::t_req r;
        int   pick;
        int   k;
        r.opcode = bfa_pkg::OP_ALLOC;
        r.frame_index = '0;
        r.kernel_only = 1'($urandom_range(1));
        r.want_write = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.opcode = bfa_pkg::OP_ALLOC;
        end else if (pick < 65) begin
            r.opcode = bfa_pkg::OP_FREE;
            if (held_frames.size() != 0) begin
                k = $urandom_range(held_frames.size() - 1);
                r.frame_index = held_frames[k];
                held_frames.delete(k);
            end else begin
                r.frame_index = 12'($urandom_range(4095));
            end
        end else if (pick < 77) begin
            r.opcode = bfa_pkg::OP_TEST;
            if (held_frames.size() != 0 && $urandom_range(1) == 1)
                r.frame_index = held_frames[$urandom_range(held_frames.size() - 1)];
            else
                r.frame_index = 12'($urandom_range(4095));
        end else if (pick < 85) begin
            r.opcode = bfa_pkg::OP_ALLOC;
            r.frame_index = 12'($urandom_range(4095, 1));
        end else if (pick < 93) begin
            r.opcode = bfa_pkg::OP_FREE;
            if ($urandom_range(3) != 0)
                r.frame_index = 12'($urandom_range(4095));
        end else begin
            r.opcode = OP_RSVD;
            r.frame_index = 12'($urandom_range(4095));
        end
        return r;
    endfunction

    // Valid is only lowered during an idle gap, so a back-to-back beat never
    // sees valid dropped and raised within one step.
    task automatic issue_req(input bfa_pkg::t_req r, input bit typed,
                             input bfa_pkg::t_rsp typed_rsp);
        bfa_pkg::t_rsp predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_frame_rsp(r);
        awaited_rsps.push_back(typed ? typed_rsp : predicted);
        if (predicted.present)
            held_frames.push_back(predicted.result_frame);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_rsps.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_frame_count(input logic [bfa_pkg::CNT_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frame_limit = v;
    endtask

    always @(posedge i_clk) begin : rsp_check
        bfa_pkg::t_rsp want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_rsps.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result beat: %p", o_out_data);
            end else begin
                want = awaited_rsps.pop_front();
                if (o_out_data.result_frame !== want.result_frame ||
                    o_out_data.present !== want.present ||
                    o_out_data.writeable !== want.writeable ||
                    o_out_data.user_mode !== want.user_mode ||
                    o_out_data.status !== want.status ||
                    o_out_data.bit_used !== want.bit_used) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result mismatch: expected %p, got %p", want, o_out_data);
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        int sent;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        frame_limit = bfa_pkg::CNT_W'(bfa_pkg::FRAME_COUNT_RST);
        foreach (used_frames[w])
            used_frames[w] = '0;

        row_chk(bfa_pkg::OP_TEST, 12'd0, 1'b0, 1'b0,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        row_chk(bfa_pkg::OP_TEST, 12'd4095, 1'b1, 1'b1,
                12'd4095, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        // Frame zero is free after reset, so the first allocation gets it.
        row_chk(bfa_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b1,
                12'd0, 1'b1, 1'b1, 1'b1, bfa_pkg::ST_DONE, 1'b0);
        row_chk(bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b0,
                12'd1, 1'b1, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        row_chk(bfa_pkg::OP_TEST, 12'd0, 1'b0, 1'b0,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b1);
        row_chk(bfa_pkg::OP_ALLOC, 12'd4095, 1'b1, 1'b1,
                12'd4095, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_NOP, 1'b0);
        row_chk(bfa_pkg::OP_FREE, 12'd0, 1'b1, 1'b1,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_NOP, 1'b0);
        row_chk(bfa_pkg::OP_FREE, 12'd1, 1'b1, 1'b1,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        row_chk(bfa_pkg::OP_TEST, 12'd1, 1'b0, 1'b0,
                12'd1, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        row_chk(OP_RSVD, 12'hAAA, 1'b1, 1'b1,
                12'hAAA, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_NOP, 1'b0);
        row_chk(OP_RSVD, 12'h555, 1'b0, 1'b0,
                12'h555, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_NOP, 1'b0);
        row_chk(bfa_pkg::OP_FREE, 12'd4095, 1'b0, 1'b1,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_DONE, 1'b0);
        row_req(bfa_pkg::OP_ALLOC, 12'd0,    1'b0, 1'b0);
        row_req(bfa_pkg::OP_TEST,  12'h800,  1'b1, 1'b0);
        // Fewer than 32 frames leaves no whole word to search.
        row_cfg(13'd5);
        row_chk(bfa_pkg::OP_ALLOC, 12'd0, 1'b0, 1'b1,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_FULL, 1'b0);
        row_cfg(13'd0);
        row_chk(bfa_pkg::OP_ALLOC, 12'd0, 1'b1, 1'b1,
                12'd0, 1'b0, 1'b0, 1'b0, bfa_pkg::ST_FULL, 1'b0);
        row_req(bfa_pkg::OP_TEST,  12'd1,    1'b1, 1'b1);
        row_cfg(13'd8191);
        row_req(bfa_pkg::OP_ALLOC, 12'd0,    1'b1, 1'b1);
        row_req(bfa_pkg::OP_ALLOC, 12'h7FF,  1'b0, 1'b1);
        row_cfg(13'd32);
        row_req(bfa_pkg::OP_ALLOC, 12'd0,    1'b0, 1'b1);
        row_req(bfa_pkg::OP_TEST,  12'd2,    1'b0, 1'b0);
        row_req(bfa_pkg::OP_FREE,  12'd2,    1'b1, 1'b0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < directed_plan.size(); i++) begin
            if (directed_plan[i].is_cfg) begin
                drain_results();
                write_frame_count(directed_plan[i].cfg_val);
            end else begin
                issue_req(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].rsp);
            end
        end

        // Each phase starts from an empty pipeline, which also makes the
        // sender hold off until every outstanding result is back.
        for (int p = 0; p < PHASE_CNT; p++) begin
            drain_results();
            write_frame_count(phase_frames[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                sent = p * ITEMS_PER_PHASE + n;
                if (sent < PHASE_CNT * ITEMS_PER_PHASE / 3) begin
                    in_idle_pct = 10;
                    out_stall_pct = 65;
                end else if (sent < 2 * PHASE_CNT * ITEMS_PER_PHASE / 3) begin
                    in_idle_pct = 65;
                    out_stall_pct = 10;
                end else begin
                    in_idle_pct = 0;
                    out_stall_pct = 0;
                end
                issue_req(random_req(), 1'b0, '0);
            end
        end

        drain_results();
        if (error_count == 0)
            $display("bitmap_frame_allocator_tb: clean");
        else
            $display("bitmap_frame_allocator_tb: errors");
        $finish;
    end

endmodule

[bitmap_frame_allocator.f]
rtl/bfa_pkg.sv
rtl/bfa_bitmap_ram.sv
rtl/bfa_search.sv
rtl/bitmap_frame_allocator.sv
sim/bitmap_frame_allocator_tb.sv
